// ===== rtl/core/irc_pkg.sv =====
package irc_pkg;

  localparam int TableSize     = 7;
  localparam int ProtocolCount = 7;
  localparam int CfgIdxW       = 4;
  localparam int CfgDataW      = 48;

  localparam logic [31:0] TimeoutLimit = 32'd500000;
  localparam logic [15:0] TickSpan     = 16'hFFFF;

  typedef logic [2:0] proto_t;

  localparam proto_t ProtoSony = 3'd2;

  typedef enum logic {
    EV_TICK    = 1'b0,
    EV_CAPTURE = 1'b1
  } event_kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RC5       = 4'd0,
    CFG_RC6       = 4'd1,
    CFG_SONY      = 4'd2,
    CFG_JVC       = 4'd3,
    CFG_NEC       = 4'd4,
    CFG_SHARP     = 4'd5,
    CFG_PANASONIC = 4'd6,
    CFG_TOLERANCE = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] interval;
    logic [15:0] lead_width;
  } entry_t;

  typedef struct packed {
    logic   hit;
    proto_t id;
  } match_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] pulse;
    logic [7:0]  edge_index;
    proto_t      protocol;
  } result_t;

endpackage

// ===== rtl/core/irc_if.sv =====
interface irc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] pulse_length;

  modport source (output valid, output kind, output pulse_length, input ready);
  modport sink (input valid, input kind, input pulse_length, output ready);
endinterface

interface irc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pulse_out;
  logic [7:0]  edge_index;
  logic [2:0]  protocol_id;

  modport source (output valid, output pulse_out, output edge_index, output protocol_id,
                  input ready);
  modport sink (input valid, input pulse_out, input edge_index, input protocol_id,
                output ready);
endinterface

interface irc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [47:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/ir_start_pulse_protocol_classifier.sv =====
// IR start-pulse protocol classifier.
// in_ch carries timer events: kind 0 is an overflow tick, kind 1 an edge capture
// with its pulse length. out_ch carries one item per forwarded pulse: the pulse
// length, the edge index and the protocol chosen by matching the pulse at edge index 2.
// cfg_ch writes the seven protocol entries (index 0..6) and the width tolerance
// (index 7); other indexes are ignored. cfg_ch.ready is always high; write only
// while no event is in flight.
// An accepted event is held in an input register, then processed against the frame state
// combinationally; a forwarded pulse is registered in the result register before it
// appears on out_ch. One event is taken every cycle while out_ch does not stall.
// When out_ch stalls, the result register holds its item and in_ch keeps taking
// events until the input register is also occupied.
// Reset clears the configuration, the frame state (protocol returns to Sony) and
// the valid flags of both registers; in_ch.ready is low while reset is asserted.
module ir_start_pulse_protocol_classifier import irc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  irc_in_if.sink   in_ch,
  irc_out_if.source out_ch,
  irc_cfg_if.sink  cfg_ch
);

  entry_t [TableSize-1:0] entries;
  logic [15:0]            tolerance;
  result_t                res;

  logic        s1_valid_r;
  logic        s1_kind_r;
  logic [15:0] s1_pulse_r;

  logic        out_valid_r;
  logic [15:0] out_pulse_r;
  logic [7:0]  out_index_r;
  proto_t      out_proto_r;

  logic advance;
  logic in_acc;

  assign cfg_ch.ready = 1'b1;
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = rst_n && (!s1_valid_r || advance);
  assign in_acc       = in_ch.valid && in_ch.ready;

  irc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (cfg_ch.valid),
    .wr_idx      (cfg_ch.index),
    .wr_data     (cfg_ch.data),
    .entries_o   (entries),
    .tolerance_o (tolerance)
  );

  irc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc_en   (s1_valid_r && advance),
    .kind      (s1_kind_r),
    .pulse     (s1_pulse_r),
    .entries   (entries),
    .tolerance (tolerance),
    .res_o     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r  <= in_ch.kind;
      s1_pulse_r <= in_ch.pulse_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_pulse_r <= res.pulse;
      out_index_r <= res.edge_index;
      out_proto_r <= res.protocol;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pulse_out   = out_pulse_r;
  assign out_ch.edge_index  = out_index_r;
  assign out_ch.protocol_id = out_proto_r;

endmodule

// ===== rtl/core/irc_cfg_regs.sv =====
module irc_cfg_regs import irc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CfgIdxW-1:0]    wr_idx,
  input  logic [CfgDataW-1:0]   wr_data,
  output entry_t [TableSize-1:0] entries_o,
  output logic [15:0]           tolerance_o
);

  entry_t [TableSize-1:0] entries_r;
  logic [15:0]            tolerance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r   <= '0;
      tolerance_r <= '0;
    end else if (wr_en) begin
      unique case (wr_idx) inside
        [CFG_RC5:CFG_PANASONIC]: begin
          entries_r[wr_idx[2:0]] <= entry_t'(wr_data);
        end
        CFG_TOLERANCE: begin
          tolerance_r <= wr_data[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign entries_o   = entries_r;
  assign tolerance_o = tolerance_r;

endmodule

// ===== rtl/core/irc_match.sv =====
module irc_match import irc_pkg::*; (
  input  entry_t [TableSize-1:0] entries,
  input  logic [15:0]            tolerance,
  input  logic [15:0]            pulse,
  output match_t                 match_o
);

  logic [15:0] hi [TableSize];
  logic [15:0] lo [TableSize];

  always_comb begin
    for (int i = 0; i < TableSize; i++) begin
      hi[i] = entries[i].lead_width + tolerance;
      lo[i] = entries[i].lead_width - tolerance;
    end
  end

  // lowest index wins
  always_comb begin
    match_o = '0;
    for (int i = ProtocolCount - 1; i >= 0; i--) begin
      if (pulse < hi[i] && pulse > lo[i]) begin
        match_o.hit = 1'b1;
        match_o.id  = proto_t'(i);
      end
    end
  end

endmodule

// ===== rtl/core/irc_core.sv =====
module irc_core import irc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   proc_en,
  input  logic                   kind,
  input  logic [15:0]            pulse,
  input  entry_t [TableSize-1:0] entries,
  input  logic [15:0]            tolerance,
  output result_t                res_o
);

  proto_t      cur_proto_r, cur_proto_nxt;
  logic [7:0]  edge_count_r, edge_count_nxt;
  logic [31:0] timeline_r, timeline_nxt;
  logic        repeat_r, repeat_nxt;

  logic [7:0]  count_inc;
  logic [31:0] tl_tick;
  logic [31:0] tl_cap;
  logic [2:0]  sel_idx;
  logic [31:0] interval_sel;
  match_t      match;

  irc_match u_match (
    .entries   (entries),
    .tolerance (tolerance),
    .pulse     (pulse),
    .match_o   (match)
  );

  assign count_inc    = edge_count_r + 8'd1;
  assign tl_tick      = timeline_r + {16'd0, TickSpan};
  assign tl_cap       = timeline_r + {16'd0, pulse};
  assign sel_idx      = (cur_proto_r == proto_t'(TableSize)) ? 3'd0 : cur_proto_r;
  assign interval_sel = entries[sel_idx].interval;

  always_comb begin
    cur_proto_nxt  = cur_proto_r;
    edge_count_nxt = edge_count_r;
    timeline_nxt   = timeline_r;
    repeat_nxt     = repeat_r;
    res_o          = '0;
    if (proc_en) begin
      if (event_kind_t'(kind) == EV_TICK) begin
        if (tl_tick >= TimeoutLimit) begin
          edge_count_nxt = '0;
          timeline_nxt   = '0;
        end else begin
          timeline_nxt = tl_tick;
        end
      end else begin
        edge_count_nxt = count_inc;
        if (count_inc == 8'd1) begin
          repeat_nxt   = (tl_cap < interval_sel);
          timeline_nxt = '0;
        end else if (count_inc == 8'd2) begin
          timeline_nxt = tl_cap;
          if (match.hit) begin
            cur_proto_nxt = match.id;
          end
        end else begin
          timeline_nxt     = tl_cap;
          res_o.valid      = !repeat_r;
          res_o.pulse      = pulse;
          res_o.edge_index = count_inc;
          res_o.protocol   = cur_proto_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_proto_r  <= ProtoSony;
      edge_count_r <= '0;
      timeline_r   <= '0;
      repeat_r     <= 1'b0;
    end else begin
      cur_proto_r  <= cur_proto_nxt;
      edge_count_r <= edge_count_nxt;
      timeline_r   <= timeline_nxt;
      repeat_r     <= repeat_nxt;
    end
  end

endmodule

// ===== rtl/core/irc_checker.sv =====
module irc_checker import irc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pulse,
  input logic [7:0]  out_index,
  input logic [2:0]  out_proto
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pulse) && $stable(out_index)
      && $stable(out_proto))
    else $error("result item changed while stalled");

  a_proto_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_proto < proto_t'(TableSize))
    else $error("protocol index out of range");

  a_no_lead_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_index != 8'd1 && out_index != 8'd2)
    else $error("first or second edge forwarded");

  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result item without an accepted event");

endmodule

bind ir_start_pulse_protocol_classifier irc_checker u_irc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_pulse (out_ch.pulse_out),
  .out_index (out_ch.edge_index),
  .out_proto (out_ch.protocol_id)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import irc_pkg::*;

  typedef struct packed {
    logic [15:0] pulse;
    logic [7:0]  edge_index;
    proto_t      protocol;
  } fwd_t;

  typedef struct packed {
    event_kind_t kind;
    logic [15:0] pulse;
    logic        typed;
    fwd_t        want;
  } step_row_t;

  typedef enum int {
    PROF_ZERO,
    PROF_FULL,
    PROF_TIGHT,
    PROF_RANDOM
  } profile_t;

  localparam int     CycleLimit  = 400000;
  localparam int     SettleTicks = 8;
  localparam int     OpeningRows = 4;
  localparam int     StepRows    = 24;
  localparam int     PhaseCount  = 7;
  localparam proto_t ProtoRc6    = 3'd1;
  localparam fwd_t   NoFwd       = '0;

  localparam step_row_t DirectedSteps [StepRows] = '{
    '{EV_CAPTURE, 16'h0000, 1'b0, NoFwd},
    '{EV_CAPTURE, 16'hFFFF, 1'b0, NoFwd},
    '{EV_CAPTURE, 16'hFFFF, 1'b1, '{16'hFFFF, 8'd3, ProtoSony}},
    '{EV_CAPTURE, 16'h0000, 1'b1, '{16'h0000, 8'd4, ProtoSony}},
    '{EV_TICK,    16'hFFFF, 1'b0, NoFwd},
    '{EV_TICK,    16'h0000, 1'b0, NoFwd},
    '{EV_TICK,    16'hFFFF, 1'b0, NoFwd},
    '{EV_TICK,    16'h0000, 1'b0, NoFwd},
    '{EV_TICK,    16'hFFFF, 1'b0, NoFwd},
    '{EV_TICK,    16'h0000, 1'b0, NoFwd},
    '{EV_TICK,    16'hFFFF, 1'b0, NoFwd},
    '{EV_CAPTURE, 16'h0000, 1'b0, NoFwd},
    '{EV_CAPTURE, 16'h8000, 1'b0, NoFwd},
    '{EV_CAPTURE, 16'hFFFF, 1'b1, '{16'hFFFF, 8'd3, ProtoRc6}},
    '{EV_TICK,    16'h0000, 1'b0, NoFwd},
    '{EV_TICK,    16'hFFFF, 1'b0, NoFwd},
    '{EV_TICK,    16'h0000, 1'b0, NoFwd},
    '{EV_TICK,    16'hFFFF, 1'b0, NoFwd},
    '{EV_TICK,    16'h0000, 1'b0, NoFwd},
    '{EV_TICK,    16'hFFFF, 1'b0, NoFwd},
    '{EV_TICK,    16'h0000, 1'b0, NoFwd},
    '{EV_CAPTURE, 16'h0001, 1'b0, NoFwd},
    '{EV_CAPTURE, 16'h0010, 1'b0, NoFwd},
    '{EV_CAPTURE, 16'h2222, 1'b0, NoFwd}
  };

  localparam profile_t PhasePlan [PhaseCount] = '{
    PROF_RANDOM, PROF_ZERO, PROF_RANDOM, PROF_FULL, PROF_TIGHT, PROF_RANDOM, PROF_RANDOM
  };
  localparam int PhaseItems [PhaseCount] = '{300, 150, 300, 150, 150, 300, 200};
  localparam int IdleOdds [3] = '{0, 3, 8};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  irc_in_if  in_ch ();
  irc_out_if out_ch ();
  irc_cfg_if cfg_ch ();

  ir_start_pulse_protocol_classifier DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  entry_t      proto_table [TableSize] = '{default: '0};
  logic [15:0] width_tol    = '0;
  proto_t      cur_proto    = ProtoSony;
  logic [7:0]  edge_cnt     = '0;
  logic [31:0] timeline_acc = '0;
  logic        repeat_frame = 1'b0;

  fwd_t        expected_fwd [$];
  int          mismatches  = 0;
  int          items_sent  = 0;
  int          cycle_count = 0;
  int          src_odds    = 3;
  int          sink_odds   = 3;
  int          stall_cnt   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign out_ch.ready = (stall_cnt == 0);

  always @(posedge clk) begin
    if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
    end else if (sink_odds != 0 && $urandom_range(1, sink_odds) == 1) begin
      stall_cnt <= $urandom_range(1, 5);
    end
  end

  function automatic logic predict_event(input event_kind_t kind, input logic [15:0] pulse,
                                         output fwd_t res);
    logic [15:0] hi;
    logic [15:0] lo;
    logic        found;
    res   = '0;
    found = 1'b0;
    if (kind == EV_TICK) begin
      timeline_acc = timeline_acc + {16'h0000, TickSpan};
      if (timeline_acc >= TimeoutLimit) begin
        edge_cnt     = '0;
        timeline_acc = '0;
      end
      return 1'b0;
    end
    edge_cnt     = edge_cnt + 8'd1;
    timeline_acc = timeline_acc + {16'h0000, pulse};
    if (edge_cnt == 8'd1) begin
      repeat_frame = timeline_acc < proto_table[cur_proto].interval;
      timeline_acc = '0;
      return 1'b0;
    end
    if (edge_cnt == 8'd2) begin
      for (int i = 0; i < ProtocolCount; i++) begin
        hi = proto_table[i].lead_width + width_tol;
        lo = proto_table[i].lead_width - width_tol;
        if (!found && pulse < hi && pulse > lo) begin
          cur_proto = proto_t'(i);
          found     = 1'b1;
        end
      end
      return 1'b0;
    end
    if (repeat_frame) return 1'b0;
    res.pulse      = pulse;
    res.edge_index = edge_cnt;
    res.protocol   = cur_proto;
    return 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    fwd_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_fwd.size() == 0) begin
        $error("unexpected item: pulse_out %0d edge_index %0d protocol_id %0d",
               out_ch.pulse_out, out_ch.edge_index, out_ch.protocol_id);
        mismatches++;
      end else begin
        want = expected_fwd.pop_front();
        check_field("pulse_out", want.pulse, out_ch.pulse_out);
        check_field("edge_index", want.edge_index, out_ch.edge_index);
        check_field("protocol_id", want.protocol, out_ch.protocol_id);
      end
    end
  end

  task automatic push_event(input event_kind_t kind, input logic [15:0] pulse,
                            input logic typed = 1'b0, input fwd_t want = '0);
    fwd_t res;
    logic hit;
    if (src_odds != 0 && $urandom_range(1, src_odds) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.pulse_length <= pulse;
    do @(posedge clk); while (!in_ch.ready);
    hit = predict_event(kind, pulse, res);
    if (typed) begin
      expected_fwd.push_back(want);
    end else if (hit) begin
      expected_fwd.push_back(res);
    end
    items_sent++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [47:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (int'(idx) < TableSize) begin
      proto_table[int'(idx)] = data;
    end else if (idx == CFG_TOLERANCE) begin
      width_tol = data[15:0];
    end
  endtask

  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    while (expected_fwd.size() != 0) @(posedge clk);
    repeat (SettleTicks) @(posedge clk);
  endtask

  task automatic load_profile(input profile_t prof);
    entry_t      e;
    logic [15:0] t;
    for (int i = 0; i < TableSize; i++) begin
      case (prof)
        PROF_ZERO: e = '0;
        PROF_FULL: e = '1;
        default: begin
          e.lead_width = 16'($urandom);
          e.interval   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 600000);
        end
      endcase
      write_reg(cfg_idx_t'(i), e);
    end
    case (prof)
      PROF_ZERO, PROF_TIGHT: t = '0;
      PROF_FULL: t = '1;
      default: t = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 1024));
    endcase
    write_reg(CFG_TOLERANCE, {32'($urandom), t});
    write_reg(cfg_idx_t'($urandom_range(int'(CFG_TOLERANCE) + 1, (1 << CfgIdxW) - 1)),
              48'({$urandom, $urandom}));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_frame();
    int          p;
    int          later;
    logic [15:0] centered;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 12))
        push_event(event_kind_t'($urandom_range(0, 1)), 16'($urandom));
      return;
    end
    repeat ($urandom_range(0, 7)) push_event(EV_TICK, 16'($urandom));
    push_event(EV_CAPTURE, 16'($urandom));
    p        = $urandom_range(0, ProtocolCount - 1);
    centered = proto_table[p].lead_width - width_tol
               + 16'($urandom_range(0, 2 * int'(width_tol)));
    push_event(EV_CAPTURE, centered);
    later = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 20);
    repeat (later) push_event(EV_CAPTURE, 16'($urandom));
    repeat (SettleTicks) push_event(EV_TICK, 16'($urandom));
  endtask

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int phase_start;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= EV_TICK;
    in_ch.pulse_length <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_RC5;
    cfg_ch.data        <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < OpeningRows; i++) begin
      push_event(DirectedSteps[i].kind, DirectedSteps[i].pulse,
                 DirectedSteps[i].typed, DirectedSteps[i].want);
    end
    drain_pipe();
    write_reg(CFG_RC5,       {32'hFFFF_FFFF, 16'h0010});
    write_reg(CFG_RC6,       {32'hFFFF_FFFF, 16'h8000});
    write_reg(CFG_SONY,      {32'h0000_0000, 16'hFFFF});
    write_reg(CFG_JVC,       {32'h0000_0000, 16'h0000});
    write_reg(CFG_NEC,       {32'h0007_A120, 16'h0030});
    write_reg(CFG_SHARP,     {32'h0001_0000, 16'h8000});
    write_reg(CFG_PANASONIC, {32'hFFFF_FFFF, 16'hFFFF});
    write_reg(CFG_TOLERANCE, {32'h0000_0000, 16'h0020});
    cfg_ch.valid <= 1'b0;
    for (int i = OpeningRows; i < StepRows; i++) begin
      push_event(DirectedSteps[i].kind, DirectedSteps[i].pulse,
                 DirectedSteps[i].typed, DirectedSteps[i].want);
    end

    for (int k = 0; k < PhaseCount; k++) begin
      drain_pipe();
      if (k == PhaseCount - 1) begin
        src_odds  = 0;
        sink_odds = 0;
      end else begin
        src_odds  = IdleOdds[$urandom_range(0, 2)];
        sink_odds = IdleOdds[$urandom_range(0, 2)];
      end
      load_profile(PhasePlan[k]);
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems[k]) run_frame();
    end

    drain_pipe();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
